### src/btpa_pkg.sv
// Shared types and constants for the prescaled auto-reload basic timer.
// Holds the word structs, mode codes, register offsets and write masks.
// No dependencies.
`default_nettype none

package btpa_pkg;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_NONE  = 2'd3
	} btpa_mode_t;

	localparam logic [3:0] OFF_CTRL1  = 4'd0;
	localparam logic [3:0] OFF_CTRL2  = 4'd1;
	localparam logic [3:0] OFF_IER    = 4'd4;
	localparam logic [3:0] OFF_STATUS = 4'd5;
	localparam logic [3:0] OFF_EGR    = 4'd6;
	localparam logic [3:0] OFF_CNT    = 4'd7;
	localparam logic [3:0] OFF_PSC    = 4'd8;
	localparam logic [3:0] OFF_ARR    = 4'd9;

	localparam logic [7:0] CTRL1_MASK    = 8'h8F;
	localparam logic [7:0] CTRL2_MASK    = 8'h70;
	localparam logic [7:0] IER_MASK      = 8'hC1;
	localparam logic [7:0] SEL_MASK      = 8'h0F;
	localparam logic [7:0] URS_UDIS_MASK = 8'h06;
	localparam logic [7:0] RELOAD_RESET  = 8'hFF;

	localparam int CTRL1_EN_BIT  = 0;
	localparam int CTRL1_OPM_BIT = 3;

	typedef struct packed {
		btpa_mode_t  mode;
		logic [3:0]  reg_offset;
		logic [7:0]  write_data;
		logic [7:0]  elapsed;
	} btpa_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       update_happened;
		logic       irq;
	} btpa_result_t;

endpackage

`default_nettype wire

### src/btpa_core.sv
// Timer register file, prescaler and counter with the per-word update logic.
// Computes one result per word in a single pass and commits state on advance.
// Depends on btpa_pkg.
`default_nettype none

module btpa_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   advance,
	input  btpa_pkg::btpa_item_t  item,
	output btpa_pkg::btpa_result_t result
);
	import btpa_pkg::*;

	logic [7:0]  ctrl1_q, ctrl2_q, ier_q, count_q, reload_q;
	logic        flag_q;
	logic [3:0]  sel_q;
	logic [14:0] accum_q;

	logic [7:0]  ctrl1_d, ctrl2_d, ier_d, count_d, reload_d;
	logic        flag_d;
	logic [3:0]  sel_d;
	logic [14:0] accum_d;

	logic [15:0] total;
	logic [15:0] expiries;
	logic [14:0] rem;
	logic [7:0]  reload_gap;
	logic        do_update;

	// Closed-form prescaler: whole periods in the accumulated cycles step the counter.
	assign total      = {1'b0, accum_q} + {8'd0, item.elapsed};
	assign expiries   = total >> sel_q;
	assign rem        = total[14:0] & ~(15'h7FFF << sel_q);
	assign reload_gap = reload_q - count_q;

	always_comb begin
		ctrl1_d   = ctrl1_q;
		ctrl2_d   = ctrl2_q;
		ier_d     = ier_q;
		flag_d    = flag_q;
		count_d   = count_q;
		reload_d  = reload_q;
		sel_d     = sel_q;
		accum_d   = accum_q;
		do_update = 1'b0;
		result    = '0;

		case (item.mode)
			MODE_TICK: begin
				if (ctrl1_q[CTRL1_EN_BIT]) begin
					if (expiries <= {8'd0, reload_gap}) begin
						count_d = count_q + expiries[7:0];
						accum_d = rem;
					end else begin
						do_update = 1'b1;
					end
				end
			end
			MODE_READ: begin
				case (item.reg_offset)
					OFF_CTRL1:  result.read_data = ctrl1_q;
					OFF_CTRL2:  result.read_data = ctrl2_q;
					OFF_IER:    result.read_data = ier_q;
					OFF_STATUS: result.read_data = {7'd0, flag_q};
					OFF_CNT:    result.read_data = count_q;
					OFF_PSC:    result.read_data = {4'd0, sel_q};
					OFF_ARR:    result.read_data = reload_q;
					default:    result.read_data = 8'd0;
				endcase
			end
			MODE_WRITE: begin
				case (item.reg_offset)
					OFF_CTRL1:  ctrl1_d = item.write_data & CTRL1_MASK;
					OFF_CTRL2:  ctrl2_d = item.write_data & CTRL2_MASK;
					OFF_IER:    ier_d = item.write_data & IER_MASK;
					OFF_STATUS: flag_d = flag_q & item.write_data[0];
					OFF_EGR: begin
						if (item.write_data[0] && ((ctrl1_q & URS_UDIS_MASK) == 8'd0)) begin
							do_update = 1'b1;
						end
					end
					OFF_CNT:    count_d = item.write_data;
					OFF_PSC:    sel_d = item.write_data[3:0] & SEL_MASK[3:0];
					OFF_ARR:    reload_d = item.write_data;
					default:    ;
				endcase
			end
			default: ;
		endcase

		// An update event overrides the counting path and drops leftover cycles.
		if (do_update) begin
			flag_d  = 1'b1;
			accum_d = '0;
			count_d = 8'd0;
			if (ctrl1_q[CTRL1_OPM_BIT]) begin
				ctrl1_d = ctrl1_q & 8'hFE;
			end
			result.update_happened = 1'b1;
			result.irq             = ier_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl1_q  <= 8'd0;
			ctrl2_q  <= 8'd0;
			ier_q    <= 8'd0;
			flag_q   <= 1'b0;
			count_q  <= 8'd0;
			reload_q <= RELOAD_RESET;
			sel_q    <= 4'd0;
			accum_q  <= 15'd0;
		end else if (advance) begin
			ctrl1_q  <= ctrl1_d;
			ctrl2_q  <= ctrl2_d;
			ier_q    <= ier_d;
			flag_q   <= flag_d;
			count_q  <= count_d;
			reload_q <= reload_d;
			sel_q    <= sel_d;
			accum_q  <= accum_d;
		end
	end

endmodule

`default_nettype wire

### src/basic_timer_prescaled_autoreload.sv
// Basic 8-bit timer with power-of-two prescaler and auto-reload, top level.
// Holds the input stage and result register around btpa_core.
// Depends on btpa_pkg and btpa_core.
//
// Usage: each input word is a tick (mode 0, elapsed cycles), a register read
// (mode 1) or a register write (mode 2), sent on in_valid/in_ready. Exactly one
// result word per input word comes back on out_valid/out_ready, carrying
// read_data, update_happened and irq, in input order.
// Path: a word accepted into the input stage is held there, evaluated against
// the timer state in one pass, and its result is registered in the result
// register, from which it is taken on out_valid/out_ready.
// Throughput: one word per cycle while out_ready is high. The input stage feeds
// the state update and the result register together, so the next word sees the
// updated timer state without a bubble.
// Stall: while out_ready is low the result register holds; the input stage
// keeps one more word, and in_ready drops only when both are full.
// Reset: arst_n clears the timer registers to their reset values (reload 255,
// prescaler shift 0, timer disabled) and empties both stages.
`default_nettype none

module basic_timer_prescaled_autoreload (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [1:0] mode,
	input  wire  [3:0] reg_offset,
	input  wire  [7:0] write_data,
	input  wire  [7:0] elapsed,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] read_data,
	output logic       update_happened,
	output logic       irq
);
	import btpa_pkg::*;

	btpa_item_t   item_s1;
	logic         valid_s1;
	btpa_result_t result;
	btpa_result_t result_q;
	logic         advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode       <= btpa_mode_t'(mode);
			item_s1.reg_offset <= reg_offset;
			item_s1.write_data <= write_data;
			item_s1.elapsed    <= elapsed;
		end
	end

	btpa_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign read_data       = result_q.read_data;
	assign update_happened = result_q.update_happened;
	assign irq             = result_q.irq;

	// An interrupt is only ever requested together with an update event.
	a_irq_needs_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && irq |-> update_happened)
		else $error("irq without update event");

	// Updates come from ticks or event writes, never from a read.
	a_update_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && update_happened |-> read_data == 8'd0)
		else $error("update result carries read data");

	// A word taken in must never overwrite an input stage that cannot advance.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !valid_s1 || advance)
		else $error("input stage overrun");

	// A word that advances always shows up as a valid result next cycle.
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced word lost");

endmodule

`default_nettype wire
